// ----- hdl/hsbrgb_pkg.sv -----
// Shared constants, types and helpers for the HSB to RGB converter.
package hsbrgb_pkg;

  localparam int FRAC_BITS = 16;
  localparam int FIELD_W   = FRAC_BITS + 1;
  localparam int PROD_W    = 2 * FIELD_W;
  localparam int BYTE_W    = 8;

  localparam logic [FIELD_W-1:0] ONE = FIELD_W'(1) << FRAC_BITS;

  // Color-wheel sector, one per sixth of a turn
  typedef enum logic [2:0] {
    SEC_RED_YELLOW   = 3'd0,
    SEC_YELLOW_GREEN = 3'd1,
    SEC_GREEN_CYAN   = 3'd2,
    SEC_CYAN_BLUE    = 3'd3,
    SEC_BLUE_MAGENTA = 3'd4,
    SEC_MAGENTA_RED  = 3'd5
  } sector_t;

  // Load strobes for the channel scaler stages
  typedef struct packed {
    logic load_prod;
    logic load_byte;
  } chan_ctl_t;

  // Limit a Q1.16 value to 1.0
  function automatic logic [FIELD_W-1:0] clamp_one(input logic [FIELD_W-1:0] v);
    logic [FIELD_W-1:0] r;
    r = (v > ONE) ? ONE : v;
    return r;
  endfunction

endpackage

// ----- hdl/hsbrgb_chan.sv -----
// One channel scaler: brightness times (1 - x), then times 255, two register stages.
module hsbrgb_chan (
  input  logic                                clk,
  input  hsbrgb_pkg::chan_ctl_t               ctl,
  input  logic [hsbrgb_pkg::FIELD_W-1:0]      bri,
  input  logic [hsbrgb_pkg::FIELD_W-1:0]      om,
  output logic [hsbrgb_pkg::BYTE_W-1:0]       level
);

  localparam int SCALED_W = hsbrgb_pkg::PROD_W + 8;

  logic [hsbrgb_pkg::PROD_W-1:0] prod;
  logic [SCALED_W-1:0]           scaled;

  // Multiply brightness by the complement term
  always_ff @(posedge clk) begin
    if (ctl.load_prod) begin
      prod <= hsbrgb_pkg::PROD_W'(bri) * hsbrgb_pkg::PROD_W'(om);
    end
  end

  // Scale by 255 as a shift and subtract, keep the byte above the 2*FRAC_BITS point
  assign scaled = (SCALED_W'(prod) << 8) - SCALED_W'(prod);

  always_ff @(posedge clk) begin
    if (ctl.load_byte) begin
      level <= scaled[2*hsbrgb_pkg::FRAC_BITS +: hsbrgb_pkg::BYTE_W];
    end
  end

endmodule

// ----- hdl/hsb_to_rgb_convert.sv -----
// Top level of the HSB to RGB converter: five-stage pipeline with stream handshakes.
//
//  channel | dir | tdata fields (low bit first)                  | tlast/tuser
//  s_*     | in  | hue[16:0] saturation[33:17] brightness[50:34] | none
//  m_*     | out | red[7:0] green[15:8] blue[23:16]              | none
//
// An accepted item passes through stages 1 to 5 to the output; one item per clock while m_tready is high.
// Each stage holds a valid bit; a stage loads when it is empty or the next stage moves on,
// so bubbles close up and a stalled output holds its item without loss or repeat.
// The stage count is set by the two multiplier ranks (s*f, then b*(1-x)) and the x255 scale.
// Reset clears only the valid bits; the data registers are not reset.
module hsb_to_rgb_convert (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // hue[16:0], saturation[33:17], brightness[50:34], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // red[7:0], green[15:8], blue[23:16]
);

  localparam int FB = hsbrgb_pkg::FRAC_BITS;
  localparam int FW = hsbrgb_pkg::FIELD_W;
  localparam int BW = hsbrgb_pkg::BYTE_W;

  // Valid bits and per-stage ready
  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5     = !v5 || m_tready;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;
  assign m_tvalid = v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  // Stage 1: unpack, wrap hue, clamp, split hue*6 into sector and fraction
  logic [FB-1:0]         hue_in;
  logic [FB+2:0]         h6;
  hsbrgb_pkg::sector_t   s1_sector;
  logic [FB-1:0]         s1_f;
  logic [FW-1:0]         s1_sat;
  logic [FW-1:0]         s1_bri;

  assign hue_in = s_tdata[FB-1:0];
  assign h6     = ((FB+3)'(hue_in) << 2) + ((FB+3)'(hue_in) << 1);

  always_ff @(posedge clk) begin
    if (rdy1 && s_tvalid) begin
      s1_sector <= hsbrgb_pkg::sector_t'(h6[FB +: 3]);
      s1_f      <= h6[FB-1:0];
      s1_sat    <= hsbrgb_pkg::clamp_one(s_tdata[FW +: FW]);
      s1_bri    <= hsbrgb_pkg::clamp_one(s_tdata[2*FW +: FW]);
    end
  end

  // Stage 2: s*f and s*(1-f), complements, brightness byte
  logic [2*FW-1:0]       sf_prod;
  logic [2*FW-1:0]       sg_prod;
  logic [FW-1:0]         sf;
  logic [FW-1:0]         sg;
  logic [FW+BW-1:0]      vb_scaled;
  hsbrgb_pkg::sector_t   s2_sector;
  logic [FW-1:0]         s2_omp;
  logic [FW-1:0]         s2_omq;
  logic [FW-1:0]         s2_omt;
  logic [FW-1:0]         s2_bri;
  logic [BW-1:0]         s2_vb;

  always_comb begin
    sf_prod   = (2*FW)'(s1_sat) * (2*FW)'(s1_f);
    sg_prod   = (2*FW)'(s1_sat) * (2*FW)'(hsbrgb_pkg::ONE - FW'(s1_f));
    sf        = sf_prod[FB +: FW];
    sg        = sg_prod[FB +: FW];
    vb_scaled = ((FW+BW)'(s1_bri) << 8) - (FW+BW)'(s1_bri);
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      s2_sector <= s1_sector;
      s2_omp    <= hsbrgb_pkg::ONE - s1_sat;
      s2_omq    <= hsbrgb_pkg::ONE - sf;
      s2_omt    <= hsbrgb_pkg::ONE - sg;
      s2_bri    <= s1_bri;
      s2_vb     <= vb_scaled[FB +: BW];
    end
  end

  // Stages 3 and 4: scale p, q and t in the channel units
  hsbrgb_pkg::chan_ctl_t chan_ctl;
  logic [BW-1:0]         vp;
  logic [BW-1:0]         vq;
  logic [BW-1:0]         vt;

  assign chan_ctl.load_prod = rdy3 && v2;
  assign chan_ctl.load_byte = rdy4 && v3;

  hsbrgb_chan u_chan_p (.clk(clk), .ctl(chan_ctl), .bri(s2_bri), .om(s2_omp), .level(vp));
  hsbrgb_chan u_chan_q (.clk(clk), .ctl(chan_ctl), .bri(s2_bri), .om(s2_omq), .level(vq));
  hsbrgb_chan u_chan_t (.clk(clk), .ctl(chan_ctl), .bri(s2_bri), .om(s2_omt), .level(vt));

  // Carry sector and brightness byte alongside the channel units
  hsbrgb_pkg::sector_t   s3_sector;
  hsbrgb_pkg::sector_t   s4_sector;
  logic [BW-1:0]         s3_vb;
  logic [BW-1:0]         s4_vb;

  always_ff @(posedge clk) begin
    if (chan_ctl.load_prod) begin
      s3_sector <= s2_sector;
      s3_vb     <= s2_vb;
    end
    if (chan_ctl.load_byte) begin
      s4_sector <= s3_sector;
      s4_vb     <= s3_vb;
    end
  end

  // Stage 5: route b, p, q, t to red, green, blue by sector
  logic [BW-1:0] red_next;
  logic [BW-1:0] green_next;
  logic [BW-1:0] blue_next;
  logic [BW-1:0] red;
  logic [BW-1:0] green;
  logic [BW-1:0] blue;

  always_comb begin
    case (s4_sector)
      hsbrgb_pkg::SEC_RED_YELLOW: begin
        red_next = s4_vb; green_next = vt;    blue_next = vp;
      end
      hsbrgb_pkg::SEC_YELLOW_GREEN: begin
        red_next = vq;    green_next = s4_vb; blue_next = vp;
      end
      hsbrgb_pkg::SEC_GREEN_CYAN: begin
        red_next = vp;    green_next = s4_vb; blue_next = vt;
      end
      hsbrgb_pkg::SEC_CYAN_BLUE: begin
        red_next = vp;    green_next = vq;    blue_next = s4_vb;
      end
      hsbrgb_pkg::SEC_BLUE_MAGENTA: begin
        red_next = vt;    green_next = vp;    blue_next = s4_vb;
      end
      default: begin
        red_next = s4_vb; green_next = vp;    blue_next = vq;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy5 && v4) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

  assign m_tdata = {blue, green, red};

`ifndef SYNTHESIS
  // Sector from a wrapped hue never passes the last wheel sector
  a_sector_range: assert property (@(posedge clk) disable iff (rst)
    v1 |-> (s1_sector <= hsbrgb_pkg::SEC_MAGENTA_RED))
    else $error("sector out of range");

  // s*f and s*(1-f) truncated never sum above s, so neither complement wraps
  a_sf_sg_bound: assert property (@(posedge clk) disable iff (rst)
    v1 |-> ((FW+1)'(sf) + (FW+1)'(sg) <= (FW+1)'(s1_sat)))
    else $error("s*f plus s*(1-f) exceeds saturation");

  // An accepted item lands in stage 1
  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> v1)
    else $error("accepted item lost at stage 1");

  // A stalled output stage keeps its data
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    (v5 && !m_tready) |=> (v5 && $stable(red) && $stable(green) && $stable(blue)))
    else $error("output changed while stalled");
`endif

endmodule

// ----- dv/hsb_to_rgb_convert_tb.sv -----
// Self-checking stream testbench for the HSB to RGB pixel converter.
`timescale 1ns / 1ps

module hsb_to_rgb_convert_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_PIXELS = 290;

  // One output pixel, laid out as on m_tdata (red in the low byte)
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  // Holds the predicted pixels in input order and checks each output against the oldest
  class rgb_scoreboard;
    rgb_t pending[$];
    int   errors = 0;

    function rgb_t predict_rgb(logic [hsbrgb_pkg::FIELD_W-1:0] hue_in,
                               logic [hsbrgb_pkg::FIELD_W-1:0] sat_in,
                               logic [hsbrgb_pkg::FIELD_W-1:0] bri_in);
      logic [63:0] one_w, sat, bri, h6, frac, sf, sg, vb, vp, vq, vt;
      hsbrgb_pkg::sector_t sector;
      rgb_t        px;
      one_w = 64'(hsbrgb_pkg::ONE);
      // Wrap hue to one turn, limit saturation and brightness to one
      sat = (sat_in > hsbrgb_pkg::ONE) ? one_w : 64'(sat_in);
      bri = (bri_in > hsbrgb_pkg::ONE) ? one_w : 64'(bri_in);
      h6 = 64'(hue_in[hsbrgb_pkg::FRAC_BITS-1:0]) * 64'd6;
      sector = hsbrgb_pkg::sector_t'(3'(h6 >> hsbrgb_pkg::FRAC_BITS));
      frac = h6 & (one_w - 64'd1);
      sf = (sat * frac) >> hsbrgb_pkg::FRAC_BITS;
      sg = (sat * (one_w - frac)) >> hsbrgb_pkg::FRAC_BITS;
      // Scale each candidate level to a byte, truncating
      vb = (bri * 64'd255) >> hsbrgb_pkg::FRAC_BITS;
      vp = (bri * (one_w - sat) * 64'd255) >> (2 * hsbrgb_pkg::FRAC_BITS);
      vq = (bri * (one_w - sf) * 64'd255) >> (2 * hsbrgb_pkg::FRAC_BITS);
      vt = (bri * (one_w - sg) * 64'd255) >> (2 * hsbrgb_pkg::FRAC_BITS);
      // Route levels to channels by sector
      case (sector)
        hsbrgb_pkg::SEC_RED_YELLOW: begin
          px.red = vb[7:0]; px.green = vt[7:0]; px.blue = vp[7:0];
        end
        hsbrgb_pkg::SEC_YELLOW_GREEN: begin
          px.red = vq[7:0]; px.green = vb[7:0]; px.blue = vp[7:0];
        end
        hsbrgb_pkg::SEC_GREEN_CYAN: begin
          px.red = vp[7:0]; px.green = vb[7:0]; px.blue = vt[7:0];
        end
        hsbrgb_pkg::SEC_CYAN_BLUE: begin
          px.red = vp[7:0]; px.green = vq[7:0]; px.blue = vb[7:0];
        end
        hsbrgb_pkg::SEC_BLUE_MAGENTA: begin
          px.red = vt[7:0]; px.green = vp[7:0]; px.blue = vb[7:0];
        end
        default: begin
          px.red = vb[7:0]; px.green = vp[7:0]; px.blue = vq[7:0];
        end
      endcase
      return px;
    endfunction

    function void note_pixel(logic [55:0] data);
      pending.push_back(predict_rgb(data[16:0], data[33:17], data[50:34]));
    endfunction

    function void check_pixel(logic [23:0] data);
      rgb_t got, want;
      got = data;
      if (pending.size() == 0) begin
        $display("%0t: unexpected pixel r=%0d g=%0d b=%0d", $time, got.red, got.green,
                 got.blue);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.red !== want.red) begin
        $display("%0t: red expected %0d actual %0d", $time, want.red, got.red);
        errors++;
      end
      if (got.green !== want.green) begin
        $display("%0t: green expected %0d actual %0d", $time, want.green, got.green);
        errors++;
      end
      if (got.blue !== want.blue) begin
        $display("%0t: blue expected %0d actual %0d", $time, want.blue, got.blue);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  int unsigned   sender_idle_pct = 0;
  int unsigned   recv_stall_pct = 0;
  int unsigned   cycles = 0;
  rgb_scoreboard sb = new();

  // First hue of each sector: smallest h with h*6 >= k*ONE
  int sector_start[6] = '{0, 10923, 21846, 32768, 43691, 54614};

  hsb_to_rgb_convert dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL hsb_to_rgb_convert");
      $finish;
    end
  end

  // Randomly stall the output side
  always @(negedge clk) begin
    m_tready = rst ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
  end

  // Check every accepted output pixel
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_pixel(m_tdata);
  end

  // Offer one pixel after a random gap, hold it until taken; starts and ends at a falling edge
  task automatic send_pixel(input logic [16:0] hue, input logic [16:0] sat,
                            input logic [16:0] bri);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {5'b0, bri, sat, hue};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_pixel(s_tdata);
    @(negedge clk);
  endtask

  // Saturation or brightness: corners, above-one values, or anything in range
  function automatic logic [16:0] pick_level();
    case ($urandom_range(9))
      0: return 17'd0;
      1: return hsbrgb_pkg::ONE;
      2: return hsbrgb_pkg::ONE - 17'd1;
      3: return 17'd1;
      4: return 17'($urandom_range(32'h1FFFF, 32'h10001));
      5: return 17'($urandom_range(32'h1FFFF));
      default: return 17'($urandom_range(32'h10000));
    endcase
  endfunction

  // Hue: sector edges, full turn, wrapped values, or anything in one turn
  function automatic logic [16:0] pick_hue();
    int k;
    k = $urandom_range(5);
    case ($urandom_range(9))
      0: return 17'(sector_start[k]);
      1: return 17'(sector_start[k] + 65535 - $urandom_range(1)) & 17'h0FFFF;
      2: return hsbrgb_pkg::ONE;
      3: return 17'($urandom_range(32'h1FFFF, 32'h10001));
      default: return 17'($urandom_range(32'hFFFF));
    endcase
  endfunction

  task automatic run_random(input int unsigned n);
    for (int i = 0; i < n; i++) send_pixel(pick_hue(), pick_level(), pick_level());
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: sector edges, full-turn and wrapped hue, level extremes, above-one clamps
    send_pixel(17'd0, hsbrgb_pkg::ONE, hsbrgb_pkg::ONE);
    send_pixel(hsbrgb_pkg::ONE, hsbrgb_pkg::ONE, hsbrgb_pkg::ONE);
    send_pixel(hsbrgb_pkg::ONE - 17'd1, hsbrgb_pkg::ONE, hsbrgb_pkg::ONE);
    send_pixel(17'd1, hsbrgb_pkg::ONE, hsbrgb_pkg::ONE);
    for (int k = 1; k < 6; k++) begin
      send_pixel(17'(sector_start[k] - 1), hsbrgb_pkg::ONE, hsbrgb_pkg::ONE);
      send_pixel(17'(sector_start[k]), hsbrgb_pkg::ONE, hsbrgb_pkg::ONE);
    end
    for (int k = 0; k < 6; k++) begin
      send_pixel(17'(sector_start[k] + 5000), 17'h08000, hsbrgb_pkg::ONE);
    end
    send_pixel(17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
    send_pixel(hsbrgb_pkg::ONE + 17'd7000, 17'd0, hsbrgb_pkg::ONE - 17'd1);
    send_pixel(17'd20000, hsbrgb_pkg::ONE, 17'd0);
    send_pixel(17'd40000, 17'h15555, 17'h0AAAA);

    // Random, through the idling phases
    run_random(PHASE_PIXELS);
    sender_idle_pct = 62;
    run_random(PHASE_PIXELS);
    sender_idle_pct = 0;
    recv_stall_pct = 62;
    run_random(PHASE_PIXELS);
    sender_idle_pct = 15;
    recv_stall_pct = 15;
    run_random(PHASE_PIXELS);
    s_tvalid = 1'b0;

    // Drain, then settle
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS hsb_to_rgb_convert");
    end else begin
      $display("FAIL hsb_to_rgb_convert");
    end
    $finish;
  end

endmodule

// ----- hsb_to_rgb_convert.f -----
hdl/hsbrgb_pkg.sv
hdl/hsbrgb_chan.sv
hdl/hsb_to_rgb_convert.sv
dv/hsb_to_rgb_convert_tb.sv
